### hdl/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, character codes and helpers for the json string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_NONE  = 2'd0;  // byte dropped, terminator only
  localparam kind_t KIND_PLAIN = 2'd1;
  localparam kind_t KIND_PAIR  = 2'd2;
  localparam kind_t KIND_UNI   = 2'd3;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [16:0] ESC_NEED   = 17'd6;
  localparam logic [16:0] PLAIN_NEED = 17'd1;
  localparam logic [15:0] CAP_RESET  = 16'd1024;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;    // plain byte, pair letter or control byte
    logic        last;
    logic [15:0] length;  // count after this byte, used on the terminator
  } job_t;

  // bytes a job emits before its terminator
  function automatic logic [2:0] kind_len(kind_t kind);
    logic [2:0] n;
    case (kind)
      KIND_PLAIN: n = 3'd1;
      KIND_PAIR:  n = 3'd2;
      KIND_UNI:   n = 3'd6;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = 8'h57 + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

### hdl/jse_if.sv
// ----------------------------------------------------------------------------
// jse_if
// Valid/ready channels carrying raw input bytes and escaped output bytes.
// ----------------------------------------------------------------------------
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in;

  modport source (output valid, output in_byte, output last_in, input ready);
  modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

interface jse_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_out;
  logic [15:0] escaped_length;

  modport source (output valid, output out_byte, output last_out,
                  output escaped_length, input ready);
  modport sink   (input valid, input out_byte, input last_out,
                  input escaped_length, output ready);
endinterface

### hdl/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Accepts input bytes, classifies them, runs the capacity check and keeps
// the running count and stop flag. Pushes a job per emitting or last byte.
// ----------------------------------------------------------------------------
module jse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  jse_in_if.sink            in_stream,
  input  logic              q_full,
  output logic              q_push,
  output jse_pkg::job_t     q_data
);

  logic [15:0] out_capacity;
  logic [15:0] written_count;
  logic        stopped;

  logic        is_esc;
  logic        is_pair;
  logic [7:0]  pair_ch;
  logic [16:0] need;
  logic        fits;
  logic        emit;
  jse_pkg::kind_t kind;
  logic [15:0] count_next;
  logic        accept;

  always_comb begin
    is_pair = 1'b1;
    pair_ch = in_stream.in_byte;
    case (in_stream.in_byte)
      jse_pkg::CH_QUOTE:  pair_ch = jse_pkg::CH_QUOTE;
      jse_pkg::CH_BSLASH: pair_ch = jse_pkg::CH_BSLASH;
      jse_pkg::CH_LF:     pair_ch = jse_pkg::CH_N;
      jse_pkg::CH_CR:     pair_ch = jse_pkg::CH_R;
      jse_pkg::CH_TAB:    pair_ch = jse_pkg::CH_T;
      default:            is_pair = 1'b0;
    endcase
    is_esc = is_pair || (in_stream.in_byte < jse_pkg::CTRL_LIMIT);
    need   = is_esc ? jse_pkg::ESC_NEED : jse_pkg::PLAIN_NEED;
    // 17 bits so count plus need never wraps
    fits   = ({1'b0, written_count} + need) < {1'b0, out_capacity};
    emit   = !stopped && fits;
    if (!emit) begin
      kind = jse_pkg::KIND_NONE;
    end else if (is_pair) begin
      kind = jse_pkg::KIND_PAIR;
    end else if (is_esc) begin
      kind = jse_pkg::KIND_UNI;
    end else begin
      kind = jse_pkg::KIND_PLAIN;
    end
    count_next = written_count + {13'd0, jse_pkg::kind_len(kind)};
  end

  assign in_stream.ready = !q_full;
  assign accept          = in_stream.valid && !q_full;
  assign q_push          = accept && (emit || in_stream.last_in);

  always_comb begin
    q_data.kind   = kind;
    q_data.data   = is_pair ? pair_ch : in_stream.in_byte;
    q_data.last   = in_stream.last_in;
    q_data.length = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity  <= jse_pkg::CAP_RESET;
      written_count <= 16'd0;
      stopped       <= 1'b0;
    end else begin
      if (cfg_we) begin
        out_capacity <= cfg_wdata;
      end
      if (accept) begin
        if (in_stream.last_in) begin
          written_count <= 16'd0;
          stopped       <= 1'b0;
        end else begin
          written_count <= count_next;
          stopped       <= stopped || !fits;
        end
      end
    end
  end

endmodule

### hdl/jse_fifo.sv
// ----------------------------------------------------------------------------
// jse_fifo
// Short show-ahead job queue between the front and the back end.
// ----------------------------------------------------------------------------
module jse_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jse_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output jse_pkg::job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jse_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Expands queued jobs into escaped output bytes, one byte per cycle while the
// sink is ready, and appends the terminator after the last byte of a string.
// ----------------------------------------------------------------------------
module jse_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  jse_pkg::job_t q_data,
  output logic          q_pop,
  jse_out_if.source     out_stream
);

  logic [2:0] idx;
  logic [2:0] body_len;
  logic [2:0] steps;
  logic       is_term;
  logic [7:0] cur_byte;
  logic       load;
  logic       final_step;

  logic        out_valid;
  logic [7:0]  out_byte;
  logic        last_out;
  logic [15:0] escaped_length;

  always_comb begin
    body_len = jse_pkg::kind_len(q_data.kind);
    steps    = body_len + {2'd0, q_data.last};
    is_term  = (idx >= body_len);
    cur_byte = jse_pkg::CH_NUL;
    if (!is_term) begin
      case (q_data.kind)
        jse_pkg::KIND_PLAIN: cur_byte = q_data.data;
        jse_pkg::KIND_PAIR:  cur_byte = (idx == 3'd0) ? jse_pkg::CH_BSLASH : q_data.data;
        jse_pkg::KIND_UNI: begin
          case (idx)
            3'd0:    cur_byte = jse_pkg::CH_BSLASH;
            3'd1:    cur_byte = jse_pkg::CH_U;
            3'd2:    cur_byte = jse_pkg::CH_ZERO;
            3'd3:    cur_byte = jse_pkg::CH_ZERO;
            3'd4:    cur_byte = jse_pkg::hex_digit(q_data.data[7:4]);
            default: cur_byte = jse_pkg::hex_digit(q_data.data[3:0]);
          endcase
        end
        default: cur_byte = jse_pkg::CH_NUL;
      endcase
    end
  end

  // output register frees as soon as the sink takes its item
  assign load       = q_valid && (!out_valid || out_stream.ready);
  assign final_step = (idx == steps - 3'd1);
  assign q_pop      = load && final_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= final_step ? 3'd0 : idx + 3'd1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte       <= cur_byte;
      last_out       <= is_term;
      escaped_length <= is_term ? q_data.length : 16'd0;
    end
  end

  assign out_stream.valid          = out_valid;
  assign out_stream.out_byte       = out_byte;
  assign out_stream.last_out       = last_out;
  assign out_stream.escaped_length = escaped_length;

endmodule

### hdl/json_string_escaper.sv
// a plain byte passes through the job queue and then the output register
// throughput: 1 item per cycle for plain bytes while the sink is ready; escapes drain
//   2 or 6 bytes, plus 1 for a terminator, at one byte per cycle from the back end sequencer
// the job queue (QUEUE_DEPTH entries) lets input run ahead of expansion
// reset: clears count, stop flag, queue and output; capacity returns to 1024
// ----------------------------------------------------------------------------
// json_string_escaper
// JSON string escaper with capacity check and terminator carrying the length.
// ----------------------------------------------------------------------------
module json_string_escaper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  jse_in_if.sink      in_stream,
  jse_out_if.source   out_stream
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  jse_pkg::job_t q_wdata;
  jse_pkg::job_t q_rdata;

  jse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_stream (in_stream),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  jse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_rdata)
  );

  jse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .out_stream (out_stream)
  );

endmodule

### bench/json_string_escaper_tb.sv
// ----------------------------------------------------------------------------
// json_string_escaper_tb
// Drives byte strings through the escaper and checks every output byte and
// terminator against typed values or an in-bench escaping predictor. A short
// table covers each escape form, the capacity limits and cut-off strings. It is
// followed by random strings under several capacities, with random stalls on
// both channels.
// ----------------------------------------------------------------------------
module json_string_escaper_tb;

  localparam int DIR_ROWS      = 29;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 46;
  localparam int ESC_BYTES     = 6;
  localparam int PLAIN_BYTES   = 1;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 120;
  localparam int RUN_LIMIT     = 600000;
  localparam logic [7:0] HEX_A = 8'h61;

  typedef enum logic [1:0] {ROW_CAP, ROW_ITEM, ROW_TYPED} row_kind_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic [15:0] len;
  } esc_result_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] cap;
    logic [7:0]  data;
    logic        fin;
    logic [2:0]  n_out;   // escaped bytes typed into outs, first byte highest
    logic [55:0] outs;
    logic [15:0] tlen;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  jse_in_if  in_ch ();
  jse_out_if out_ch ();

  json_string_escaper uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_stream  (in_ch),
    .out_stream (out_ch)
  );

  // escaper state as seen from outside
  logic [15:0] cap_reg;
  logic [15:0] wr_count;
  logic        cut_off;

  esc_result_t step_q[$];
  esc_result_t expected_q[$];
  esc_result_t want;

  int errors;
  int results_seen;
  int bytes_sent;
  int strings_done;
  int cut_strings;
  int cycle_count;
  int hold_reqs;
  int holds_served;
  int hold_left;
  int rx_gap;
  int rx_run;
  bit rx_calm;

  function automatic stim_row_t cap_row(input logic [15:0] v);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CAP;
    r.cap = v;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic [7:0] b, input logic fin);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.data = b;
    r.fin = fin;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] b, input logic fin,
                                          input logic [2:0] n, input logic [55:0] outs,
                                          input logic [15:0] tlen);
    stim_row_t r;
    r = item_row(b, fin);
    r.kind = ROW_TYPED;
    r.n_out = n;
    r.outs = outs;
    r.tlen = tlen;
    return r;
  endfunction

  stim_row_t directed_rows [0:DIR_ROWS-1] = '{
    typed_row("A",                1'b0, 3'd1, "A",        16'd0),
    typed_row(8'h00,              1'b0, 3'd6, "\\u0000",  16'd0),
    typed_row(8'h1f,              1'b0, 3'd6, "\\u001f",  16'd0),
    typed_row(jse_pkg::CH_QUOTE,  1'b0, 3'd2, "\\\"",     16'd0),
    typed_row(jse_pkg::CH_BSLASH, 1'b0, 3'd2, "\\\\",     16'd0),
    typed_row(jse_pkg::CH_LF,     1'b0, 3'd2, "\\n",      16'd0),
    typed_row(jse_pkg::CH_CR,     1'b0, 3'd2, "\\r",      16'd0),
    typed_row(jse_pkg::CH_TAB,    1'b0, 3'd2, "\\t",      16'd0),
    typed_row(8'hff,              1'b1, 3'd1, 56'hff,     16'd24),
    item_row(8'h20, 1'b0),
    item_row(8'h7f, 1'b0),
    item_row(8'h80, 1'b0),
    item_row(8'h21, 1'b1),
    // capacity one leaves room for the terminator only
    cap_row(16'd1),
    typed_row("A",                1'b1, 3'd0, 56'd0,      16'd0),
    cap_row(16'd0),
    typed_row(jse_pkg::CH_LF,     1'b1, 3'd0, 56'd0,      16'd0),
    // stopped string drops a byte that would still fit
    cap_row(16'd7),
    typed_row(jse_pkg::CH_LF,     1'b0, 3'd2, "\\n",      16'd0),
    typed_row(8'h02,              1'b0, 3'd0, 56'd0,      16'd0),
    typed_row("z",                1'b0, 3'd0, 56'd0,      16'd0),
    typed_row("q",                1'b1, 3'd0, 56'd0,      16'd2),
    typed_row(8'h01,              1'b0, 3'd6, "\\u0001",  16'd0),
    typed_row("x",                1'b1, 3'd0, 56'd0,      16'd6),
    cap_row(16'd2),
    typed_row("k",                1'b0, 3'd1, "k",        16'd0),
    item_row("m", 1'b1),
    cap_row(16'hffff),
    item_row(8'h7e, 1'b1)
  };

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? jse_pkg::CH_ZERO + 8'(nib) : HEX_A + 8'(nib) - 8'd10;
  endfunction

  // escaped bytes of one input byte go to step_q, state advances
  function automatic void escape_predict(input logic [7:0] c, input logic fin);
    logic [7:0] seq [0:5];
    int n;
    n = 0;
    step_q.delete();
    if (!cut_off) begin
      if (c < jse_pkg::CTRL_LIMIT || c == jse_pkg::CH_QUOTE || c == jse_pkg::CH_BSLASH) begin
        if (int'(wr_count) + ESC_BYTES >= int'(cap_reg)) begin
          cut_off = 1'b1;
        end else begin
          seq[0] = jse_pkg::CH_BSLASH;
          n = 2;
          case (c)
            jse_pkg::CH_QUOTE:  seq[1] = jse_pkg::CH_QUOTE;
            jse_pkg::CH_BSLASH: seq[1] = jse_pkg::CH_BSLASH;
            jse_pkg::CH_LF:     seq[1] = jse_pkg::CH_N;
            jse_pkg::CH_CR:     seq[1] = jse_pkg::CH_R;
            jse_pkg::CH_TAB:    seq[1] = jse_pkg::CH_T;
            default: begin
              seq[1] = jse_pkg::CH_U;
              seq[2] = jse_pkg::CH_ZERO;
              seq[3] = jse_pkg::CH_ZERO;
              seq[4] = hex_char(c[7:4]);
              seq[5] = hex_char(c[3:0]);
              n = 6;
            end
          endcase
        end
      end else if (int'(wr_count) + PLAIN_BYTES >= int'(cap_reg)) begin
        cut_off = 1'b1;
      end else begin
        seq[0] = c;
        n = 1;
      end
    end
    for (int i = 0; i < n; i++) begin
      step_q.push_back('{seq[i], 1'b0, 16'd0});
    end
    wr_count = wr_count + 16'(n);
    if (fin) begin
      step_q.push_back('{jse_pkg::CH_NUL, 1'b1, wr_count});
      strings_done++;
      if (cut_off) begin
        cut_strings++;
      end
      wr_count = '0;
      cut_off = 1'b0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 45);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // leaves valid high; the caller lowers it when a gap follows
  task automatic send_row(input stim_row_t r);
    int n;
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= r.data;
    in_ch.last_in <= r.fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    escape_predict(r.data, r.fin);
    if (r.kind == ROW_TYPED) begin
      n = int'(r.n_out);
      for (int i = 0; i < n; i++) begin
        expected_q.push_back('{r.outs[8*(n-1-i) +: 8], 1'b0, 16'd0});
      end
      if (r.fin) begin
        expected_q.push_back('{jse_pkg::CH_NUL, 1'b1, r.tlen});
      end
    end else begin
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    end
  endtask

  // dropped bytes give no result, so let the block settle after the last one
  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(input logic [15:0] v);
    drain_and_settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_reg = v;
  endtask

  always #1 clk = ~clk;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // output side: check each item, then choose ready for the next edge
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got byte %0h last %0b length %0d",
                 $time, out_ch.out_byte, out_ch.last_out, out_ch.escaped_length);
      end else begin
        want = expected_q.pop_front();
        check_field("out_byte", 16'(want.data), 16'(out_ch.out_byte));
        check_field("last_out", 16'(want.fin), 16'(out_ch.last_out));
        check_field("escaped_length", want.len, out_ch.escaped_length);
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (holds_served != hold_reqs) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (rx_run == 0) begin
        rx_run = $urandom_range(10, 80);
        rx_calm = ($urandom_range(0, 3) == 0);
      end else begin
        rx_run--;
      end
      if (!rx_calm && $urandom_range(0, 2) == 0) begin
        rx_gap = pick_gap();
      end
    end
  end

  initial begin
    int p;
    int k;
    int g;
    int r;
    int str_left;
    bit tx_calm;
    logic [7:0] b;
    logic [15:0] cap_v;

    cap_reg = jse_pkg::CAP_RESET;
    wr_count = '0;
    cut_off = 1'b0;
    str_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CAP) begin
        write_cap(directed_rows[i].cap);
      end else begin
        send_row(directed_rows[i]);
      end
    end

    // strings run across phase boundaries, so some capacity writes land mid-string
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       cap_v = jse_pkg::CAP_RESET;
        1:       cap_v = 16'($urandom_range(8, 40));
        2:       cap_v = 16'hffff;
        3:       cap_v = 16'h0000;
        4:       cap_v = 16'($urandom_range(0, 65535));
        5:       cap_v = 16'd1;
        6:       cap_v = 16'($urandom_range(2, 20));
        default: cap_v = 16'($urandom_range(2, 80));
      endcase
      write_cap(cap_v);
      tx_calm = (p == 2) || ($urandom_range(0, 3) == 0);
      // long output hold while the input keeps coming
      if (p == 2) begin
        hold_reqs++;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (str_left == 0) begin
          str_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 10);
        end
        str_left--;
        r = $urandom_range(0, 99);
        if (r < 45) begin
          b = 8'($urandom_range(8'h20, 8'h7e));
        end else if (r < 60) begin
          b = 8'($urandom_range(0, 8'h1f));
        end else if (r < 66) begin
          b = jse_pkg::CH_QUOTE;
        end else if (r < 72) begin
          b = jse_pkg::CH_BSLASH;
        end else if (r < 80) begin
          case ($urandom_range(0, 2))
            0:       b = jse_pkg::CH_LF;
            1:       b = jse_pkg::CH_CR;
            default: b = jse_pkg::CH_TAB;
          endcase
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        send_row(item_row(b, str_left == 0));
        if (!tx_calm && $urandom_range(0, 9) < 3) begin
          g = pick_gap();
          in_ch.valid <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end

    drain_and_settle();
    $display("sent %0d bytes, %0d strings closed (%0d cut short), %0d output items checked",
             bytes_sent, strings_done, cut_strings, results_seen);
    $display("capacities from 0 to 65535, all escape forms, long output hold");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
